// File: design/tnt_pkg.sv
// ----------------------------------------------------------------------------
// tnt_pkg
// Shared types and constants for the top-N newest tracker.
// ----------------------------------------------------------------------------
package tnt_pkg;

	localparam int CAP   = 8;
	localparam int KEY_W = 40;
	localparam int TAG_W = 16;
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int IDX_W = $clog2(CAP);

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_CLEAR  = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	// result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_EVICTED   = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_DROPPED   = 3'd3;
	localparam logic [2:0] ST_CLEARED   = 3'd4;
	localparam logic [2:0] ST_READ_OK   = 3'd5;
	localparam logic [2:0] ST_RANGE     = 3'd6;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_UP,
		CM_DOWN
	} cell_mode_t;

	// broadcast from control to every cell
	typedef struct packed {
		logic              cmp_en;
		cell_mode_t        mode;
		logic [KEY_W-1:0]  key;
		logic [TAG_W-1:0]  tag;
	} cell_ctl_t;

	// what a cell shows its neighbors and the control
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TAG_W-1:0]  tag;
		logic              gt;
		logic              lt;
		logic              eq;
	} cell_out_t;

endpackage

// File: design/tnt_cell.sv
// ----------------------------------------------------------------------------
// tnt_cell
// One slot of the sorted chain: holds a key and tag, compares against the
// broadcast key and shifts from either neighbor on update.
// ----------------------------------------------------------------------------
module tnt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  tnt_pkg::cell_ctl_t ctl,
	input  logic               valid,
	input  logic               prev_valid,
	input  tnt_pkg::cell_out_t prev_cell,
	input  tnt_pkg::cell_out_t next_cell,
	output tnt_pkg::cell_out_t slot
);

	logic [tnt_pkg::KEY_W-1:0] key_q;
	logic [tnt_pkg::TAG_W-1:0] tag_q;
	logic                      gt_q;
	logic                      lt_q;
	logic                      eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= 1'b0;
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			gt_q <= valid && (key_q > ctl.key);
			lt_q <= valid && (key_q < ctl.key);
			eq_q <= valid && (key_q == ctl.key);
		end
	end

	// up: larger entries move toward the top, new key lands at its slot
	// down: smaller entries move toward slot 0, dropping the old minimum
	always_ff @(posedge clk) begin
		case (ctl.mode)
			tnt_pkg::CM_UP: begin
				if (prev_cell.gt) begin
					key_q <= prev_cell.key;
					tag_q <= prev_cell.tag;
				end else if (gt_q || (!valid && prev_valid)) begin
					key_q <= ctl.key;
					tag_q <= ctl.tag;
				end
			end
			tnt_pkg::CM_DOWN: begin
				if (next_cell.lt) begin
					key_q <= next_cell.key;
					tag_q <= next_cell.tag;
				end else if (lt_q) begin
					key_q <= ctl.key;
					tag_q <= ctl.tag;
				end
			end
			default: begin
			end
		endcase
	end

	assign slot.key = key_q;
	assign slot.tag = tag_q;
	assign slot.gt  = gt_q;
	assign slot.lt  = lt_q;
	assign slot.eq  = eq_q;

endmodule

// File: design/top_n_newest_tracker_unit.sv
// ----------------------------------------------------------------------------
// top_n_newest_tracker_unit
// Sorted table of the CAP largest distinct keys with tags, built as a chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request transaction:
//   insert key+tag, clear, or read entry by index. Output channel
//   (out_valid/out_ready) returns exactly one result transaction per request:
//   status, count after the request, and key/tag for a successful read.
//   Timing: a request accepted in the idle state is compared in all cells
//   in the compare state and applied in the update state, where the result
//   is registered; out_valid rises right after. This order is set by the
//   compare-then-shift sequence through the cell chain; in_ready is high
//   only in the idle state.
//   A result waiting in the output register does not block the next
//   request from being taken and compared; that request holds before its
//   update step until the receiver takes the pending result.
//   Reset clears the entry count and handshake state; cell contents are
//   left undefined and are never returned before being written.
// ----------------------------------------------------------------------------
module top_n_newest_tracker_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                req_type,
	input  logic [tnt_pkg::KEY_W-1:0] key,
	input  logic [tnt_pkg::TAG_W-1:0] entry_tag,
	input  logic [2:0]                read_index,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2:0]                status,
	output logic [3:0]                count,
	output logic [tnt_pkg::KEY_W-1:0] out_key,
	output logic [tnt_pkg::TAG_W-1:0] out_tag
);

	localparam int CAP   = tnt_pkg::CAP;
	localparam int CNT_W = tnt_pkg::CNT_W;
	localparam int IDX_W = tnt_pkg::IDX_W;
	// width wide enough to compare a read index against the count
	localparam int CMP_W = (IDX_W + 3 > CNT_W) ? IDX_W + 3 : CNT_W;

	tnt_pkg::state_t state_q, state_d;

	// captured request
	logic [1:0]                req_q;
	logic [tnt_pkg::KEY_W-1:0] key_q;
	logic [tnt_pkg::TAG_W-1:0] tag_q;
	logic [2:0]                idx_q;

	logic [CNT_W-1:0] cnt_q;

	// result register
	logic                      out_valid_q;
	logic [2:0]                status_q;
	logic [3:0]                count_q;
	logic [tnt_pkg::KEY_W-1:0] out_key_q;
	logic [tnt_pkg::TAG_W-1:0] out_tag_q;

	// chain wiring
	tnt_pkg::cell_ctl_t ctl;
	tnt_pkg::cell_out_t cells   [CAP];
	logic [CAP-1:0]     valid_v;
	logic [CAP-1:0]     eq_v;

	// control decode
	logic                      in_acc;
	logic                      upd_go;
	logic                      dup;
	logic                      full;
	logic                      rd_hit;
	logic [IDX_W+2:0]          idx_wide;
	logic [IDX_W-1:0]          rd_sel;
	tnt_pkg::cell_mode_t       mode_d;
	logic [2:0]                res_status;
	logic [CNT_W-1:0]          res_cnt;
	logic [tnt_pkg::KEY_W-1:0] res_key;
	logic [tnt_pkg::TAG_W-1:0] res_tag;
	logic [CNT_W+3:0]          res_cnt_wide;

	assign in_acc = in_valid && in_ready;
	// update only when the result register is free (or being drained)
	assign upd_go = (state_q == tnt_pkg::S_UPD) && (!out_valid_q || out_ready);

	// ---------------------------------------------------------------- FSM
	always_comb begin
		state_d = state_q;
		case (state_q)
			tnt_pkg::S_IDLE: if (in_valid) state_d = tnt_pkg::S_CMP;
			tnt_pkg::S_CMP:  state_d = tnt_pkg::S_UPD;
			tnt_pkg::S_UPD:  if (upd_go) state_d = tnt_pkg::S_IDLE;
			default:         state_d = tnt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == tnt_pkg::S_IDLE);
		ctl.cmp_en = (state_q == tnt_pkg::S_CMP);
		ctl.mode   = upd_go ? mode_d : tnt_pkg::CM_HOLD;
		ctl.key    = key_q;
		ctl.tag    = tag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tnt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture: payload only, no reset
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q <= req_type;
			key_q <= key;
			tag_q <= entry_tag;
			idx_q <= read_index;
		end
	end

	// ---------------------------------------------------------------- cell chain
	// cell 0 sees a "previous" slot that is valid and never greater;
	// the last cell sees a "next" slot that is never smaller.
	genvar gi;
	generate
		for (gi = 0; gi < CAP; gi++) begin : g_cell
			tnt_pkg::cell_out_t prev_c;
			tnt_pkg::cell_out_t next_c;
			logic               prev_v;

			assign valid_v[gi] = CNT_W'(gi) < cnt_q;
			assign eq_v[gi]    = cells[gi].eq;

			if (gi == 0) begin : g_first
				assign prev_c = '0;
				assign prev_v = 1'b1;
			end else begin : g_mid
				assign prev_c = cells[gi-1];
				assign prev_v = valid_v[gi-1];
			end

			if (gi == CAP - 1) begin : g_last
				assign next_c = '0;
			end else begin : g_inner
				assign next_c = cells[gi+1];
			end

			tnt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.valid      (valid_v[gi]),
				.prev_valid (prev_v),
				.prev_cell  (prev_c),
				.next_cell  (next_c),
				.slot       (cells[gi])
			);
		end
	endgenerate

	// ---------------------------------------------------------------- result decode
	assign dup      = |eq_v;
	assign full     = (cnt_q == CNT_W'(CAP));
	assign idx_wide = {{IDX_W{1'b0}}, idx_q};
	assign rd_sel   = idx_wide[IDX_W-1:0];
	// an index below the count is always below CAP too
	assign rd_hit   = CMP_W'(idx_q) < CMP_W'(cnt_q);

	always_comb begin
		mode_d     = tnt_pkg::CM_HOLD;
		res_status = tnt_pkg::ST_RANGE;
		res_cnt    = cnt_q;
		res_key    = '0;
		res_tag    = '0;
		case (req_q)
			tnt_pkg::REQ_INSERT: begin
				if (dup) begin
					res_status = tnt_pkg::ST_DUPLICATE;
				end else if (!full) begin
					// sorted insert, larger entries shift up by one
					res_status = tnt_pkg::ST_INSERTED;
					res_cnt    = cnt_q + CNT_W'(1);
					mode_d     = tnt_pkg::CM_UP;
				end else if (cells[0].lt) begin
					// full and newer than the oldest: drop slot 0, shift down
					res_status = tnt_pkg::ST_EVICTED;
					mode_d     = tnt_pkg::CM_DOWN;
				end else begin
					res_status = tnt_pkg::ST_DROPPED;
				end
			end
			tnt_pkg::REQ_CLEAR: begin
				res_status = tnt_pkg::ST_CLEARED;
				res_cnt    = '0;
			end
			tnt_pkg::REQ_READ: begin
				if (rd_hit) begin
					res_status = tnt_pkg::ST_READ_OK;
					res_key    = cells[rd_sel].key;
					res_tag    = cells[rd_sel].tag;
				end
			end
			default: begin
				res_status = tnt_pkg::ST_RANGE;
			end
		endcase
	end

	// count port carries only the low four bits
	assign res_cnt_wide = {4'b0, res_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd_go) begin
				cnt_q       <= res_cnt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			status_q  <= res_status;
			count_q   <= res_cnt_wide[3:0];
			out_key_q <= res_key;
			out_tag_q <= res_tag;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign count     = count_q;
	assign out_key   = out_key_q;
	assign out_tag   = out_tag_q;

endmodule

// File: bench/top_n_newest_tracker_unit_test.sv
// ----------------------------------------------------------------------------
// top_n_newest_tracker_unit_test
// Self-checking bench for the top-N newest tracker: directed corner cases,
// then random request streams. A shadow table predicts each result, and
// both channels are exercised with random gaps and a long output stall.
// ----------------------------------------------------------------------------
module top_n_newest_tracker_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	// request code with no function; block must answer with range status
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// recent timestamp used as the center of dense key sets
	localparam logic [tnt_pkg::KEY_W-1:0] TS_BASE = 40'd202401011200;

	typedef struct packed {
		logic [2:0]                status;
		logic [3:0]                count;
		logic [tnt_pkg::KEY_W-1:0] key;
		logic [tnt_pkg::TAG_W-1:0] tag;
	} tracker_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                req_type;
	logic [tnt_pkg::KEY_W-1:0] key;
	logic [tnt_pkg::TAG_W-1:0] entry_tag;
	logic [2:0]                read_index;
	logic                      out_valid;
	logic                      out_ready;
	logic [2:0]                status;
	logic [3:0]                count;
	logic [tnt_pkg::KEY_W-1:0] out_key;
	logic [tnt_pkg::TAG_W-1:0] out_tag;

	// shadow copy of the table, updated when a request transaction is taken
	logic [tnt_pkg::KEY_W-1:0] shadow_keys [tnt_pkg::CAP];
	logic [tnt_pkg::TAG_W-1:0] shadow_tags [tnt_pkg::CAP];
	int                        shadow_count;

	tracker_result_t  pending_results[$];
	int               mismatch_count;
	bit               tx_lazy;
	bit               rx_lazy;
	int               rx_hold;

	top_n_newest_tracker_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.key        (key),
		.entry_tag  (entry_tag),
		.read_index (read_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.count      (count),
		.out_key    (out_key),
		.out_tag    (out_tag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling: several times the slowest legal run
	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Applies one request to the shadow table and returns the result it owes.
	function automatic tracker_result_t tracker_predict(input logic [1:0] req,
			input logic [tnt_pkg::KEY_W-1:0] k, input logic [tnt_pkg::TAG_W-1:0] t,
			input logic [2:0] idx);
		tracker_result_t r;
		int              i;
		int              p;
		bit              dup;
		r   = '0;
		dup = 1'b0;
		case (req)
			tnt_pkg::REQ_INSERT: begin
				for (i = 0; i < shadow_count; i++)
					if (shadow_keys[i] == k)
						dup = 1'b1;
				if (dup) begin
					r.status = tnt_pkg::ST_DUPLICATE;
				end else if (shadow_count < tnt_pkg::CAP) begin
					// room left: shift larger keys up, drop new one into the hole
					p = shadow_count;
					while (p > 0 && shadow_keys[p-1] > k) begin
						shadow_keys[p] = shadow_keys[p-1];
						shadow_tags[p] = shadow_tags[p-1];
						p--;
					end
					shadow_keys[p] = k;
					shadow_tags[p] = t;
					shadow_count++;
					r.status = tnt_pkg::ST_INSERTED;
				end else if (k > shadow_keys[0]) begin
					// full: oldest falls out, smaller keys slide down
					p = 0;
					while (p < tnt_pkg::CAP - 1 && shadow_keys[p+1] < k) begin
						shadow_keys[p] = shadow_keys[p+1];
						shadow_tags[p] = shadow_tags[p+1];
						p++;
					end
					shadow_keys[p] = k;
					shadow_tags[p] = t;
					r.status = tnt_pkg::ST_EVICTED;
				end else begin
					r.status = tnt_pkg::ST_DROPPED;
				end
			end
			tnt_pkg::REQ_CLEAR: begin
				shadow_count = 0;
				r.status     = tnt_pkg::ST_CLEARED;
			end
			tnt_pkg::REQ_READ: begin
				if (idx < shadow_count) begin
					r.key    = shadow_keys[idx];
					r.tag    = shadow_tags[idx];
					r.status = tnt_pkg::ST_READ_OK;
				end else begin
					r.status = tnt_pkg::ST_RANGE;
				end
			end
			default: begin
				r.status = tnt_pkg::ST_RANGE;
			end
		endcase
		r.count = 4'(shadow_count);
		return r;
	endfunction

	function automatic logic [tnt_pkg::KEY_W-1:0] any_key();
		return {8'($urandom_range(0, 255)), 32'($urandom())};
	endfunction

	// Offers one request transaction; returns at the edge that takes it.
	// Handshake is judged at the falling edge, where every signal is settled.
	task automatic send_request(input logic [1:0] req, input logic [tnt_pkg::KEY_W-1:0] k,
			input logic [tnt_pkg::TAG_W-1:0] t, input logic [2:0] idx);
		int gap;
		gap = tx_lazy ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		key        <= k;
		entry_tag  <= t;
		read_index <= idx;
		do @(negedge clk); while (!in_ready);
		pending_results.push_back(tracker_predict(req, k, t, idx));
		@(posedge clk);
	endtask

	task automatic insert_key(input logic [tnt_pkg::KEY_W-1:0] k,
			input logic [tnt_pkg::TAG_W-1:0] t);
		send_request(tnt_pkg::REQ_INSERT, k, t, 3'($urandom()));
	endtask

	task automatic read_entry(input logic [2:0] idx);
		send_request(tnt_pkg::REQ_READ, any_key(), 16'($urandom()), idx);
	endtask

	// One random request; insert keys come from a dense window, from the
	// table itself (duplicates) or from the whole 40-bit space.
	task automatic send_random_request();
		int                        pick;
		int                        src;
		logic [tnt_pkg::KEY_W-1:0] k;
		pick = $urandom_range(0, 99);
		src  = $urandom_range(0, 99);
		if (src < 40)
			k = TS_BASE + 40'($urandom_range(0, 63));
		else if (src < 65 && shadow_count > 0)
			k = shadow_keys[$urandom_range(0, shadow_count - 1)];
		else
			k = any_key();
		if (pick < 62)
			send_request(tnt_pkg::REQ_INSERT, k, 16'($urandom()), 3'($urandom()));
		else if (pick < 97)
			send_request(tnt_pkg::REQ_READ, k, 16'($urandom()), 3'($urandom()));
		else if (pick < 99)
			send_request(tnt_pkg::REQ_CLEAR, k, 16'($urandom()), 3'($urandom()));
		else
			send_request(REQ_UNUSED, k, 16'($urandom()), 3'($urandom()));
	endtask

	// --- directed tests -----------------------------------------------------

	// reads past count, the unused code and a clear, all on an empty table
	task automatic test_empty_table();
		read_entry(3'd0);
		read_entry(3'd7);
		send_request(REQ_UNUSED, '1, '1, 3'd7);
		send_request(tnt_pkg::REQ_CLEAR, '1, '1, 3'd7);
	endtask

	// extreme keys, a duplicate, then out-of-order inserts up to full
	task automatic test_fill_and_order();
		insert_key('1, '1);
		insert_key('0, '0);
		insert_key('0, 16'h1234);
		read_entry(3'd0);
		read_entry(3'd1);
		insert_key(TS_BASE + 40'd50, 16'h0050);
		insert_key(TS_BASE + 40'd10, 16'h0010);
		insert_key(TS_BASE + 40'd30, 16'h0030);
		insert_key(TS_BASE + 40'd20, 16'h0020);
		insert_key(TS_BASE + 40'd40, 16'h0040);
		insert_key(TS_BASE + 40'd60, 16'h0060);
		read_entry(3'd7);
		read_entry(3'd0);
	endtask

	// full table: evict at the low end, drop, duplicate, evict into the middle
	task automatic test_full_table();
		insert_key(TS_BASE + 40'd5, 16'hA005);
		insert_key(40'd1, 16'hA001);
		insert_key(TS_BASE + 40'd30, 16'hA030);
		insert_key(TS_BASE + 40'd35, 16'hA035);
		read_entry(3'd0);
		read_entry(3'd3);
	endtask

	// cleared entries must not be readable until written again
	task automatic test_clear();
		send_request(tnt_pkg::REQ_CLEAR, any_key(), 16'($urandom()), 3'($urandom()));
		read_entry(3'd0);
		insert_key(TS_BASE, 16'hBEEF);
		read_entry(3'd0);
	endtask

	// --- random tests -------------------------------------------------------

	// mixed requests; idling on each side switched per stretch of 50 requests
	task automatic test_random_mix();
		int n;
		for (n = 0; n < 1000; n++) begin
			if (n % 50 == 0) begin
				tx_lazy = ($urandom_range(0, 9) < 7);
				rx_lazy = ($urandom_range(0, 9) < 7);
			end
			send_random_request();
		end
	endtask

	// newest-arrival pattern: rising timestamps with a few stale ones and reads
	task automatic test_ascending_stream();
		int                        n;
		int                        pick;
		logic [tnt_pkg::KEY_W-1:0] ts;
		ts      = TS_BASE;
		tx_lazy = 1'b1;
		rx_lazy = 1'b1;
		for (n = 0; n < 250; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				ts = ts + 40'($urandom_range(1, 5));
				insert_key(ts, 16'($urandom()));
			end else if (pick < 80) begin
				insert_key(ts - 40'($urandom_range(0, 60)), 16'($urandom()));
			end else begin
				read_entry(3'($urandom()));
			end
		end
	endtask

	// back-to-back random traffic, neither side idles
	task automatic test_dense_burst();
		int n;
		tx_lazy = 1'b0;
		rx_lazy = 1'b0;
		for (n = 0; n < 150; n++)
			send_random_request();
	endtask

	// receiver stalls for a long stretch while requests keep coming, so the
	// block backs up and drops in_ready
	task automatic test_backpressure();
		int n;
		tx_lazy = 1'b0;
		rx_lazy = 1'b0;
		rx_hold = 150;
		for (n = 0; n < 16; n++)
			send_random_request();
	endtask

	// --- result side --------------------------------------------------------

	// Draws a stall per result, honors a requested long hold, then compares
	// each result transaction against the oldest prediction.
	initial begin
		int              stall;
		tracker_result_t exp_r;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_lazy ? $urandom_range(0, 10) : 0;
			if (rx_hold > 0) begin
				stall   = rx_hold;
				rx_hold = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: status=%0d count=%0d key=%h tag=%h",
						status, count, out_key, out_tag);
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.status || count !== exp_r.count ||
						out_key !== exp_r.key || out_tag !== exp_r.tag) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"mismatch: exp status=%0d count=%0d key=%h tag=%h,",
							" got status=%0d count=%0d key=%h tag=%h"},
							exp_r.status, exp_r.count, exp_r.key, exp_r.tag,
							status, count, out_key, out_tag);
				end
			end
			@(posedge clk);
		end
	end

	// --- sequence -----------------------------------------------------------

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		req_type       <= tnt_pkg::REQ_INSERT;
		key            <= '0;
		entry_tag      <= '0;
		read_index     <= '0;
		shadow_count   = 0;
		mismatch_count = 0;
		tx_lazy        = 1'b1;
		rx_lazy        = 1'b1;
		rx_hold        = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_and_order();
		test_full_table();
		test_clear();
		test_random_mix();
		test_backpressure();
		test_ascending_stream();
		test_dense_burst();
		in_valid <= 1'b0;

		// drain, then leave room for any stray extra result
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
